@@ src/sdsa_pkg.sv @@
`default_nettype none
package sdsa_pkg;

    localparam int CHANNELS   = 8;
    localparam int ADC_BITS   = 12;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CHANNEL_W  = 3;
    localparam int SAMPLE_W   = 12;
    localparam int FRAC_W     = 8;
    localparam int LEVEL_W    = SAMPLE_W + FRAC_W;
    localparam int WEIGHT_W   = 9;
    localparam int DEADZONE_W = 12;
    localparam int ANGLE_W    = 8;
    localparam int MAX_ANGLE  = 180;
    localparam int WEIGHT_ONE = 256;
    localparam int PROD_W     = LEVEL_W + WEIGHT_W;

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam logic REG_WEIGHT   = 1'b0;
    localparam logic REG_DEADZONE = 1'b1;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET   = WEIGHT_W'(64);
    localparam logic [DEADZONE_W-1:0] DEADZONE_RESET = DEADZONE_W'(20);

    // floor(L*180/(2^ADC_BITS-1)) == (L*ANGLE_RECIP) >> ANGLE_SHIFT for every 12-bit L
    localparam int FULL_SCALE    = (1 << ADC_BITS) - 1;
    localparam int ANGLE_SHIFT   = SAMPLE_W + ADC_BITS;
    localparam int ANGLE_RECIP_W = 21;
    localparam logic [ANGLE_RECIP_W-1:0] ANGLE_RECIP = ANGLE_RECIP_W'(
        ((64'(MAX_ANGLE) << ANGLE_SHIFT) / 64'(FULL_SCALE)) + 64'd1);
    localparam int SCALE_W       = SAMPLE_W + ANGLE_RECIP_W;

    typedef struct packed {
        logic [WEIGHT_W-1:0]   weight;
        logic [DEADZONE_W-1:0] deadzone;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [SAMPLE_W-1:0] accepted;
    } chan_entry_t;

endpackage
`default_nettype wire

@@ src/sdsa_cfg_regs.sv @@
`default_nettype none
module sdsa_cfg_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sdsa_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sdsa_pkg::PDATA_W-1:0] pwdata,
    output logic      [sdsa_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output sdsa_pkg::cfg_t                   cfg
);
    import sdsa_pkg::*;

    logic [WEIGHT_W-1:0]   weight_reg;
    logic [DEADZONE_W-1:0] deadzone_reg;
    logic                  wr_en;
    logic                  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg   <= WEIGHT_RESET;
            deadzone_reg <= DEADZONE_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_WEIGHT:   weight_reg   <= pwdata[WEIGHT_W-1:0];
                REG_DEADZONE: deadzone_reg <= pwdata[DEADZONE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_WEIGHT:   prdata = PDATA_W'(weight_reg);
            REG_DEADZONE: prdata = PDATA_W'(deadzone_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.weight   = weight_reg;
    assign cfg.deadzone = deadzone_reg;

endmodule
`default_nettype wire

@@ src/sdsa_chan_mem.sv @@
`default_nettype none
module sdsa_chan_mem (
    input  wire logic                         aclk,
    input  wire logic                         rd_en,
    input  wire logic [sdsa_pkg::CH_IDX_W-1:0] rd_addr,
    output sdsa_pkg::chan_entry_t             rd_data,
    input  wire logic                         wr_en,
    input  wire logic [sdsa_pkg::CH_IDX_W-1:0] wr_addr,
    input  wire sdsa_pkg::chan_entry_t        wr_data
);
    import sdsa_pkg::*;

    chan_entry_t mem [CHANNELS];
    chan_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ src/smoothed_deadband_servo_angle_core.sv @@
// Smoothed deadband servo angle core.
// Input channel (s_valid/s_ready): one ADC sample with its channel number.
// Result channel (m_valid/m_ready): exactly one result per input transaction,
// carrying the channel, the servo angle of the smoothed level, and the
// command/active flags (set when the sample moved beyond the deadzone).
// Per-channel average and last accepted sample live in a one-port-read,
// one-port-write synchronous RAM; seeded flags are flip-flops.
// After an input transaction the core reads the channel RAM, multiplies,
// updates and writes back the average, and scales the angle as the output
// register loads and m_valid rises; s_ready returns then too, so one item is in
// flight at a time, set by this read-modify-write sequence on the channel RAM.
// The result sits in an output register; a stalled receiver holds the core in
// its last step until the register frees. One more sample may be accepted and
// processed up to that step while a result waits.
// Reset: weight 64, deadzone 20, all channels unseeded; no clearing pass.
// The first sample of a channel seeds it and gives command 0, active 0.
// The user must write configuration over the APB port only while the core is
// idle; the core does not enforce it.
`default_nettype none
module smoothed_deadband_servo_angle_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sdsa_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [sdsa_pkg::PDATA_W-1:0]  pwdata,
    output logic      [sdsa_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [sdsa_pkg::CHANNEL_W-1:0] s_channel,
    input  wire logic [sdsa_pkg::SAMPLE_W-1:0] s_sample,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [sdsa_pkg::CHANNEL_W-1:0] m_out_channel,
    output logic      [sdsa_pkg::ANGLE_W-1:0]  m_angle,
    output logic                               m_command,
    output logic                               m_active
);
    import sdsa_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_MIX   = 2'd2;
    localparam logic [1:0] ST_ANGLE = 2'd3;

    cfg_t        cfg;
    chan_entry_t rd_entry;
    chan_entry_t wr_entry;

    logic [1:0]            state_reg;
    logic [CHANNEL_W-1:0]  ch_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic                  in_range_reg;
    logic                  seed_reg;
    logic                  move_reg;
    logic [SAMPLE_W-1:0]   accepted_reg;
    logic [PROD_W-1:0]     prod_old_reg;
    logic [PROD_W-1:0]     prod_new_reg;
    logic [SAMPLE_W-1:0]   level_int_reg;
    logic                  cmd_reg;
    logic [CHANNELS-1:0]   seeded_reg;

    logic                  m_valid_reg;
    logic [CHANNEL_W-1:0]  m_channel_reg;
    logic [ANGLE_W-1:0]    m_angle_reg;
    logic                  m_command_reg;

    logic                  accept;
    logic [CH_IDX_W-1:0]   s_idx;
    logic [CH_IDX_W-1:0]   idx;
    logic [WEIGHT_W-1:0]   w_eff;
    logic [WEIGHT_W-1:0]   w_inv;
    logic [SAMPLE_W-1:0]   diff;
    logic [PROD_W:0]       mix_sum;
    logic [LEVEL_W-1:0]    level_next;
    logic [SCALE_W-1:0]    scale_prod;
    logic [SCALE_W-ANGLE_SHIFT-1:0] angle_raw;
    logic [ANGLE_W-1:0]    angle_next;
    logic                  out_free;
    logic                  out_load;

    sdsa_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid & s_ready;
    assign s_idx   = CH_IDX_W'(s_channel);
    assign idx     = CH_IDX_W'(ch_reg);

    sdsa_chan_mem u_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (s_idx),
        .rd_data (rd_entry),
        .wr_en   ((state_reg == ST_MIX) && in_range_reg),
        .wr_addr (idx),
        .wr_data (wr_entry)
    );

    always_comb begin
        w_eff = (cfg.weight > WEIGHT_W'(WEIGHT_ONE)) ? WEIGHT_W'(WEIGHT_ONE) : cfg.weight;
        w_inv = WEIGHT_W'(WEIGHT_ONE) - w_eff;
        diff  = (sample_reg > rd_entry.accepted) ? (sample_reg - rd_entry.accepted)
                                                 : (rd_entry.accepted - sample_reg);
        mix_sum    = {1'b0, prod_old_reg} + {1'b0, prod_new_reg};
        level_next = seed_reg ? {sample_reg, FRAC_W'(0)}
                              : mix_sum[FRAC_W +: LEVEL_W];
        wr_entry.level    = level_next;
        wr_entry.accepted = seed_reg ? sample_reg : accepted_reg;

        scale_prod = SCALE_W'(level_int_reg) * SCALE_W'(ANGLE_RECIP);
        angle_raw  = scale_prod[SCALE_W-1:ANGLE_SHIFT];
        if (!in_range_reg) begin
            angle_next = '0;
        end else if (angle_raw > (SCALE_W-ANGLE_SHIFT)'(MAX_ANGLE)) begin
            angle_next = ANGLE_W'(MAX_ANGLE);
        end else begin
            angle_next = ANGLE_W'(angle_raw);
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_ANGLE) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            seeded_reg  <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        ch_reg       <= s_channel;
                        sample_reg   <= s_sample;
                        in_range_reg <= (32'(s_channel) < CHANNELS);
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: begin
                    seed_reg     <= !seeded_reg[idx];
                    move_reg     <= diff > cfg.deadzone;
                    accepted_reg <= (diff > cfg.deadzone) ? sample_reg : rd_entry.accepted;
                    prod_old_reg <= PROD_W'(rd_entry.level) * PROD_W'(w_inv);
                    prod_new_reg <= PROD_W'({sample_reg, FRAC_W'(0)}) * PROD_W'(w_eff);
                    state_reg    <= ST_MIX;
                end
                ST_MIX: begin
                    level_int_reg <= level_next[LEVEL_W-1:FRAC_W];
                    cmd_reg       <= in_range_reg && !seed_reg && move_reg;
                    if (in_range_reg) begin
                        seeded_reg[idx] <= 1'b1;
                    end
                    state_reg <= ST_ANGLE;
                end
                ST_ANGLE: begin
                    if (out_free) begin
                        m_channel_reg <= ch_reg;
                        m_angle_reg   <= angle_next;
                        m_command_reg <= cmd_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_channel_reg;
    assign m_angle       = m_angle_reg;
    assign m_command     = m_command_reg;
    assign m_active      = m_command_reg;

endmodule
`default_nettype wire

@@ bench/smoothed_deadband_servo_angle_core_tb.sv @@
`timescale 1ns / 100ps
module smoothed_deadband_servo_angle_core_tb;
    import sdsa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 160;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [PADDR_W-1:0] ADDR_WEIGHT   = {REG_WEIGHT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_DEADZONE = {REG_DEADZONE, 2'b00};

    typedef struct packed {
        logic [CHANNEL_W-1:0] ch;
        logic [SAMPLE_W-1:0]  sample;
    } sample_item_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] ch;
        logic [ANGLE_W-1:0]   angle;
        logic                 command;
        logic                 active;
    } servo_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CHANNEL_W-1:0]  s_channel = '0;
    logic [SAMPLE_W-1:0]   s_sample = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CHANNEL_W-1:0]  m_out_channel;
    logic [ANGLE_W-1:0]    m_angle;
    logic                  m_command;
    logic                  m_active;

    smoothed_deadband_servo_angle_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_channel(s_channel), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_channel(m_out_channel),
        .m_angle(m_angle), .m_command(m_command), .m_active(m_active)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [WEIGHT_W-1:0]   cur_weight = WEIGHT_RESET;
    logic [DEADZONE_W-1:0] cur_deadzone = DEADZONE_RESET;
    logic [LEVEL_W-1:0]    avg_level [CHANNELS];
    logic [SAMPLE_W-1:0]   held_sample [CHANNELS];
    logic                  seeded [CHANNELS];

    // stimulus-side tracking of the accepted sample, to aim at the deadzone edge
    int gen_held [CHANNELS];
    bit gen_seeded [CHANNELS];

    sample_item_t  sample_queue [$];
    servo_result_t predicted_results [$];

    int errors = 0;
    int cycle_count = 0;
    int samples_sent = 0;
    int results_checked = 0;
    int commands_seen = 0;
    int settings_used = 1;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            avg_level[i] = '0;
            held_sample[i] = '0;
            seeded[i] = 1'b0;
            gen_held[i] = 0;
            gen_seeded[i] = 1'b0;
        end
    end

    function automatic logic [ANGLE_W-1:0] level_angle(input logic [LEVEL_W-1:0] level);
        longint a;
        a = (longint'(level >> FRAC_W) * MAX_ANGLE) / ((1 << ADC_BITS) - 1);
        if (a > MAX_ANGLE)
            a = MAX_ANGLE;
        return ANGLE_W'(a);
    endfunction

    function automatic servo_result_t next_servo_result(input sample_item_t it);
        servo_result_t r;
        longint w;
        longint mix;
        int diff;
        int c;
        c = int'(it.ch);
        r.ch = it.ch;
        r.angle = '0;
        r.command = 1'b0;
        r.active = 1'b0;
        if (c >= CHANNELS)
            return r;
        if (!seeded[c]) begin
            seeded[c] = 1'b1;
            avg_level[c] = {it.sample, {FRAC_W{1'b0}}};
            held_sample[c] = it.sample;
            r.angle = level_angle(avg_level[c]);
            return r;
        end
        w = (cur_weight > WEIGHT_ONE) ? WEIGHT_ONE : longint'(cur_weight);
        mix = longint'(avg_level[c]) * (WEIGHT_ONE - w) + (longint'(it.sample) << FRAC_W) * w;
        avg_level[c] = LEVEL_W'(mix >> FRAC_W);
        diff = int'(it.sample) - int'(held_sample[c]);
        if (diff < 0)
            diff = -diff;
        if (diff > int'(cur_deadzone)) begin
            held_sample[c] = it.sample;
            r.command = 1'b1;
            r.active = 1'b1;
        end
        r.angle = level_angle(avg_level[c]);
        return r;
    endfunction

    // sender: bursts with random gaps
    always @(posedge aclk) begin
        sample_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_results.push_back(next_servo_result({s_channel, s_sample}));
                samples_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || sample_queue.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    it = sample_queue.pop_front();
                    s_channel <= it.ch;
                    s_sample <= it.sample;
                    s_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 11);
                    end
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // receiver: checks results, stalls on a changing pattern
    always @(posedge aclk) begin
        servo_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_results.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual ch=%0d angle=%0d",
                         $time, m_out_channel, m_angle);
                errors++;
            end else begin
                want = predicted_results.pop_front();
                check_field("out_channel", want.ch, m_out_channel);
                check_field("angle", want.angle, m_angle);
                check_field("command", want.command, m_command);
                check_field("active", want.active, m_active);
                results_checked++;
                if (m_command)
                    commands_seen++;
            end
        end
        if (cycle_count % 300 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (cycle_count % 7 < 3);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input int value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_WEIGHT)
            cur_weight = WEIGHT_W'(value);
        else
            cur_deadzone = DEADZONE_W'(value);
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (sample_queue.size() != 0 || s_valid || predicted_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_sample(input int ch, input int value);
        int d;
        if (!gen_seeded[ch]) begin
            gen_seeded[ch] = 1'b1;
            gen_held[ch] = value;
        end else begin
            d = value - gen_held[ch];
            if (d < 0)
                d = -d;
            if (d > int'(cur_deadzone))
                gen_held[ch] = value;
        end
        sample_queue.push_back({CHANNEL_W'(ch), SAMPLE_W'(value)});
    endtask

    task automatic queue_random_samples(input int count);
        int ch;
        int dz;
        int delta;
        int value;
        dz = int'(cur_deadzone);
        for (int n = 0; n < count; n++) begin
            ch = $urandom_range(0, CHANNELS - 1);
            case ($urandom_range(0, 5))
                0: delta = -1;
                1, 2: delta = $urandom_range(0, dz);
                3: delta = dz + 1;
                default: delta = dz + 1 + $urandom_range(0, 200);
            endcase
            if (delta < 0) begin
                value = $urandom_range(0, 4095);
            end else begin
                value = $urandom_range(0, 1) ? gen_held[ch] + delta : gen_held[ch] - delta;
                if (value < 0)
                    value = 0;
                if (value > 4095)
                    value = 4095;
            end
            queue_sample(ch, value);
        end
    endtask

    int weight_plan [8]   = '{1, 256, 0, 511, 128, 255, 64, 3};
    int deadzone_plan [8] = '{0, 4095, 5, 100, 20, 1, 300, 4094};

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // seeding, deadzone edge, full-scale swings at reset settings
        queue_sample(0, 0);
        queue_sample(7, 4095);
        queue_sample(1, 2048);
        queue_sample(2, 1);
        queue_sample(3, 4094);
        queue_sample(4, 2047);
        queue_sample(5, 1365);
        queue_sample(6, 2730);
        queue_sample(0, 20);
        queue_sample(0, 21);
        queue_sample(0, 0);
        queue_sample(7, 0);
        queue_sample(7, 4095);
        queue_sample(1, 2068);
        queue_sample(1, 2089);
        queue_sample(2, 1);
        queue_sample(3, 0);
        queue_sample(5, 4095);
        queue_sample(6, 12'h555);
        queue_sample(4, 12'hAAA);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            reg_write(ADDR_WEIGHT, weight_plan[p]);
            reg_write(ADDR_DEADZONE, deadzone_plan[p]);
            settings_used++;
            queue_random_samples(RANDOM_PER_PHASE);
            wait_idle();
        end

        $display("%0d samples over %0d weight/deadzone settings, %0d results checked",
                 samples_sent, settings_used, results_checked);
        $display("%0d servo commands seen, %0d mismatches", commands_seen, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
